/* rtl/gsm7_septet_unpacker_macros.svh */
`ifndef GSM7_SEPTET_UNPACKER_MACROS_SVH
`define GSM7_SEPTET_UNPACKER_MACROS_SVH

// check a property outside reset
`define GSM7_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define GSM7_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gsm7_pkg.sv */
package gsm7_pkg;

  localparam int TABLE_ENTRIES     = 128;
  localparam int TABLE_ADDR_BITS   = $clog2(TABLE_ENTRIES);
  localparam int SEPTET_BITS       = 7;
  localparam int POSITION_BITS_DEF = 16;
  localparam int UNIT_BITS         = 16;
  localparam int BUF_BITS          = 15;
  localparam int CNT_BITS          = 4;

  localparam logic [SEPTET_BITS-1:0] ESC_SEPTET = 7'h1b;
  localparam logic [UNIT_BITS-1:0]   SPACE_UNIT = 16'h0020;

  typedef enum logic [1:0] {
    OP_LOAD_LOCKING = 2'd0,
    OP_LOAD_SINGLE  = 2'd1,
    OP_OCTET        = 2'd2
  } opcode_t;

endpackage

/* rtl/gsm7_septet_unpacker.sv */
// First result: work register, a step per leading escape, then read and meta registers.
// Throughput: one step per cycle in the issue stage unless the output stalls; a table load
// takes one step, an octet one per released septet plus one for a closing space (0 to 4).
// The single table RAM (read or write once a cycle) sets that figure.
// Reset (rst, synchronous): mode packed, bit buffer, escape and position cleared,
// pipeline emptied; table contents are kept and undefined until loaded.
module gsm7_septet_unpacker #(
  parameter int POSITION_BITS = gsm7_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [6:0]  table_index,
  input  logic [15:0] table_value,
  input  logic [7:0]  octet,
  input  logic        message_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic [15:0] position,
  output logic        run_last
);

  localparam int SB  = gsm7_pkg::SEPTET_BITS;
  localparam int AB  = gsm7_pkg::TABLE_ADDR_BITS;
  localparam int UB  = gsm7_pkg::UNIT_BITS;
  localparam int BB  = gsm7_pkg::BUF_BITS;
  localparam int CB  = gsm7_pkg::CNT_BITS;
  localparam int MEM_DEPTH = 2 * gsm7_pkg::TABLE_ENTRIES;

  logic packed_mode;

  logic [BB-1:0] bit_buffer, bit_buffer_next;
  logic [CB-1:0] bit_count, bit_count_next;

  logic [BB-1:0]        drained, appended;
  logic [CB-1:0]        rem_count;
  logic [1:0]           n_drain;
  logic [2:0][SB-1:0]   d_sep;
  logic [1:0]           d_nsep;
  logic                 d_enter;
  gsm7_pkg::opcode_t    in_op;
  logic                 accept;

  logic                 w_valid;
  gsm7_pkg::opcode_t    w_kind;
  logic [2:0][SB-1:0]   w_sep;
  logic [1:0]           w_nsep;
  logic                 w_flush;
  logic                 w_last;
  logic [SB-1:0]        w_index;
  logic [UB-1:0]        w_value;

  logic                     esc, esc_next;
  logic [POSITION_BITS-1:0] char_count;
  logic [POSITION_BITS+15:0] cc_ext;

  logic adv, step, done, emit, is_space, slot_last, rd_en, wr_en, is_esc, rem_live;

  logic [UB-1:0] table_mem [MEM_DEPTH];
  logic [UB-1:0] rdata;
  logic [AB:0]   raddr, waddr;

  logic          b_valid;
  logic          b_space;
  logic [15:0]   b_pos;
  logic          b_last;

  assign in_op  = gsm7_pkg::opcode_t'(opcode);
  assign adv    = !b_valid || out_ready;
  assign step   = w_valid && adv;
  assign in_ready = !w_valid || (adv && done);
  assign accept = in_valid && in_ready;
  assign cc_ext = {16'b0, char_count};

  // decode an octet beat into its septets
  always_comb begin
    if (bit_count >= CB'(14)) begin
      n_drain   = 2'd2;
      drained   = bit_buffer >> 14;
      rem_count = bit_count - CB'(14);
    end else if (bit_count >= CB'(7)) begin
      n_drain   = 2'd1;
      drained   = bit_buffer >> 7;
      rem_count = bit_count - CB'(7);
    end else begin
      n_drain   = 2'd0;
      drained   = bit_buffer;
      rem_count = bit_count;
    end
    appended = (drained | ({7'b0, octet} << rem_count));

    if (packed_mode) begin
      d_sep[0] = (n_drain == 2'd0) ? appended[SB-1:0] : bit_buffer[SB-1:0];
      d_sep[1] = (n_drain == 2'd2) ? bit_buffer[2*SB-1:SB] : appended[SB-1:0];
      d_sep[2] = appended[SB-1:0];
      d_nsep   = n_drain + 2'(message_last);
    end else begin
      d_sep[0] = octet[SB-1:0];
      d_sep[1] = octet[SB-1:0];
      d_sep[2] = octet[SB-1:0];
      d_nsep   = 2'd1;
    end

    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    if (message_last) begin
      bit_buffer_next = '0;
      bit_count_next  = '0;
    end else if (packed_mode) begin
      bit_buffer_next = appended;
      bit_count_next  = rem_count + CB'(8);
    end

    unique case (in_op)
      gsm7_pkg::OP_LOAD_LOCKING: d_enter = 1'b1;
      gsm7_pkg::OP_LOAD_SINGLE:  d_enter = 1'b1;
      gsm7_pkg::OP_OCTET:        d_enter = (d_nsep != 2'd0);
      default:                   d_enter = 1'b0;
    endcase
  end

  // issue one step of the held beat
  always_comb begin
    is_esc    = (w_sep[0] == gsm7_pkg::ESC_SEPTET);
    rem_live  = ((w_nsep > 2'd1) && (w_sep[1] != gsm7_pkg::ESC_SEPTET)) ||
                ((w_nsep > 2'd2) && (w_sep[2] != gsm7_pkg::ESC_SEPTET));
    emit      = 1'b0;
    is_space  = 1'b0;
    slot_last = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    esc_next  = esc;
    done      = 1'b0;
    if (w_valid) begin
      if (w_kind != gsm7_pkg::OP_OCTET) begin
        wr_en = 1'b1;
        done  = 1'b1;
      end else if (w_nsep != 2'd0) begin
        if (is_esc) begin
          esc_next = 1'b1;
        end else begin
          esc_next  = 1'b0;
          rd_en     = 1'b1;
          emit      = 1'b1;
          slot_last = !rem_live && !((w_nsep > 2'd1) && w_flush);
        end
        done = (w_nsep == 2'd1) && !(w_flush && esc_next);
      end else begin
        emit      = 1'b1;
        is_space  = 1'b1;
        slot_last = 1'b1;
        done      = 1'b1;
      end
    end
  end

  assign raddr = {esc, w_sep[0]};
  assign waddr = {(w_kind == gsm7_pkg::OP_LOAD_SINGLE), w_index};

  always_ff @(posedge clk) begin
    if (wr_en && step) begin
      table_mem[waddr] <= w_value;
    end
    if (rd_en && step) begin
      rdata <= table_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packed_mode <= 1'b1;
      bit_buffer  <= '0;
      bit_count   <= '0;
      w_valid     <= 1'b0;
      esc         <= 1'b0;
      char_count  <= '0;
      b_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        packed_mode <= cfg_write_data;
      end
      if (accept && (in_op == gsm7_pkg::OP_OCTET)) begin
        bit_buffer <= bit_buffer_next;
        bit_count  <= bit_count_next;
      end

      if (accept) begin
        w_valid <= d_enter;
      end else if (step && done) begin
        w_valid <= 1'b0;
      end

      if (step) begin
        if (done && w_last) begin
          esc        <= 1'b0;
          char_count <= '0;
        end else begin
          esc <= esc_next;
          if (emit && (char_count != '1)) begin
            char_count <= char_count + POSITION_BITS'(1);
          end
        end
      end

      if (adv) begin
        b_valid <= step && emit;
      end
    end
  end

  // work register and result meta: payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      w_kind  <= in_op;
      w_sep   <= d_sep;
      w_nsep  <= d_nsep;
      w_flush <= packed_mode && message_last;
      w_last  <= message_last && (in_op == gsm7_pkg::OP_OCTET);
      w_index <= table_index;
      w_value <= table_value;
    end else if (step && (w_nsep != 2'd0)) begin
      w_sep[0] <= w_sep[1];
      w_sep[1] <= w_sep[2];
      w_nsep   <= w_nsep - 2'd1;
    end

    if (step) begin
      b_space <= is_space;
      b_pos   <= cc_ext[15:0];
      b_last  <= slot_last;
    end
  end

  assign out_valid = b_valid;
  assign code_unit = (b_space || (rdata == '0)) ? gsm7_pkg::SPACE_UNIT : rdata;
  assign position  = b_pos;
  assign run_last  = b_last;

endmodule

/* rtl/gsm7_checker.sv */
`include "gsm7_septet_unpacker_macros.svh"

module gsm7_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic        run_last
);

  `GSM7_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(code_unit) && $stable(run_last)), "result beat dropped or changed while stalled")
  `GSM7_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result beat shown right after reset")
  `GSM7_ASSERT(a_no_zero_unit, out_valid |-> (code_unit != 16'h0000), "zero code unit not replaced by a space")

endmodule

bind gsm7_septet_unpacker gsm7_checker u_gsm7_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .code_unit (code_unit),
  .run_last  (run_last)
);

/* test/tb_gsm7_septet_unpacker.sv */
`timescale 1ns / 100ps

module tb_gsm7_septet_unpacker;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned POS_MAX = (1 << gsm7_pkg::POSITION_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 30;
  localparam int CALM_ITEMS = 10;

  typedef struct {
    logic [1:0]  op;
    logic [6:0]  index;
    logic [15:0] value;
    logic [7:0]  octet;
    logic        last;
  } beat_t;

  typedef struct {
    logic [15:0] unit;
    logic [15:0] pos;
    logic        last;
  } char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [6:0]  table_index = '0;
  logic [15:0] table_value = '0;
  logic [7:0]  octet = '0;
  logic        message_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic [15:0] position;
  logic        run_last;

  logic [15:0] lock_units [gsm7_pkg::TABLE_ENTRIES];
  logic [15:0] shift_units[gsm7_pkg::TABLE_ENTRIES];
  logic [14:0] held_bits = '0;
  int unsigned held_count = 0;
  bit          esc_armed = 1'b0;
  int unsigned char_tally = 0;
  bit          packed_mode_m = 1'b1;
  char_t       beat_chars[$];
  char_t       expected_chars[$];

  bit valid_up = 1'b0;
  bit src_bursts = 1'b0;
  bit sink_bursts = 1'b0;
  bit hold_req = 1'b0;
  int beats_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  gsm7_septet_unpacker #(
    .POSITION_BITS(gsm7_pkg::POSITION_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .table_index(table_index),
    .table_value(table_value),
    .octet(octet),
    .message_last(message_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .code_unit(code_unit),
    .position(position),
    .run_last(run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void emit_char(logic [15:0] unit);
    char_t c;
    c.unit = unit;
    c.pos = char_tally[15:0];
    c.last = 1'b0;
    beat_chars.push_back(c);
    if (char_tally < POS_MAX) char_tally++;
  endfunction

  function automatic void decode_septet(logic [6:0] s);
    logic [15:0] u;
    if (s == gsm7_pkg::ESC_SEPTET) begin
      esc_armed = 1'b1;
      return;
    end
    if (esc_armed) begin
      esc_armed = 1'b0;
      u = shift_units[s];
    end else begin
      u = lock_units[s];
    end
    emit_char((u != 16'h0000) ? u : gsm7_pkg::SPACE_UNIT);
  endfunction

  function automatic void predict_beat(beat_t b);
    logic [22:0] merged;
    beat_chars.delete();
    case (b.op)
      gsm7_pkg::OP_LOAD_LOCKING: lock_units[b.index] = b.value;
      gsm7_pkg::OP_LOAD_SINGLE: shift_units[b.index] = b.value;
      gsm7_pkg::OP_OCTET: begin
        if (packed_mode_m) begin
          while (held_count >= gsm7_pkg::SEPTET_BITS) begin
            decode_septet(held_bits[6:0]);
            held_bits = held_bits >> gsm7_pkg::SEPTET_BITS;
            held_count -= gsm7_pkg::SEPTET_BITS;
          end
          merged = {8'd0, held_bits} | (23'(b.octet) << held_count);
          held_bits = merged[14:0];
          held_count += 8;
          if (b.last && held_count >= gsm7_pkg::SEPTET_BITS) begin
            decode_septet(held_bits[6:0]);
            if (esc_armed) emit_char(gsm7_pkg::SPACE_UNIT);
          end
        end else begin
          decode_septet(b.octet[6:0]);
        end
        if (b.last) begin
          held_bits = '0;
          held_count = 0;
          esc_armed = 1'b0;
          char_tally = 0;
        end
      end
      default: ;
    endcase
    if (beat_chars.size() > 0) beat_chars[$].last = 1'b1;
    foreach (beat_chars[i]) expected_chars.push_back(beat_chars[i]);
  endfunction

  function automatic beat_t octet_beat(logic [7:0] oct, logic last);
    beat_t b;
    b.op = gsm7_pkg::OP_OCTET;
    b.index = 7'($urandom);
    b.value = 16'($urandom);
    b.octet = oct;
    b.last = last;
    return b;
  endfunction

  function automatic beat_t load_beat(logic [1:0] op, logic [6:0] idx, logic [15:0] val);
    beat_t b;
    b.op = op;
    b.index = idx;
    b.value = val;
    b.octet = 8'($urandom);
    b.last = 1'($urandom);
    return b;
  endfunction

  function automatic logic [15:0] table_word();
    return ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
  endfunction

  function automatic logic [6:0] rand_septet();
    return ($urandom_range(0, 5) == 0) ? gsm7_pkg::ESC_SEPTET : 7'($urandom);
  endfunction

  task automatic lower_valid;
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic send_beat(input beat_t b);
    if (src_bursts && $urandom_range(0, 3) == 0) begin
      lower_valid();
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    valid_up = 1'b1;
    opcode <= b.op;
    table_index <= b.index;
    table_value <= b.value;
    octet <= b.octet;
    message_last <= b.last;
    do @(posedge clk); while (!in_ready);
    predict_beat(b);
    if (b.op != OP_RESERVED) beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input logic [6:0] septs[$]);
    logic [127:0] stream;
    int noct;
    stream = {$urandom, $urandom, $urandom, $urandom};
    if (packed_mode_m) begin
      foreach (septs[i]) stream[7*i +: 7] = septs[i];
      noct = (7 * septs.size() + 7) / 8;
      for (int i = 0; i < noct; i++) send_beat(octet_beat(stream[8*i +: 8], i == noct - 1));
    end else begin
      foreach (septs[i]) send_beat(octet_beat({1'($urandom), septs[i]}, i == septs.size() - 1));
    end
  endtask

  task automatic quiesce;
    lower_valid();
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input bit m);
    quiesce();
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    packed_mode_m = m;
  endtask

  task automatic test_load_tables;
    for (int i = 0; i < gsm7_pkg::TABLE_ENTRIES; i++) begin
      send_beat(load_beat(gsm7_pkg::OP_LOAD_LOCKING, 7'(i),
                          (i == gsm7_pkg::TABLE_ENTRIES - 1) ? 16'hffff : table_word()));
      send_beat(load_beat(gsm7_pkg::OP_LOAD_SINGLE, 7'(i), (i == 0) ? 16'h0000 : table_word()));
    end
  endtask

  task automatic test_packed_messages;
    beat_t b;
    set_mode(1'b1);
    send_beat(octet_beat(8'hff, 1'b0));
    send_beat(octet_beat(8'h00, 1'b1));
    send_message('{gsm7_pkg::ESC_SEPTET, 7'h41});
    send_message('{7'h10, gsm7_pkg::ESC_SEPTET});
    send_message('{gsm7_pkg::ESC_SEPTET, gsm7_pkg::ESC_SEPTET, 7'h05});
    send_beat(octet_beat(8'h5a, 1'b0));
    b = load_beat(OP_RESERVED, 7'h7f, 16'hffff);
    b.last = 1'b1;
    send_beat(b);
    b = load_beat(gsm7_pkg::OP_LOAD_LOCKING, 7'h00, 16'h0040);
    b.last = 1'b1;
    send_beat(b);
    send_beat(octet_beat(8'h3c, 1'b1));
    send_message('{7'h7f, 7'h00, 7'h55, 7'h2a, 7'h1a, 7'h1c, 7'h01, 7'h7e});
  endtask

  task automatic test_unpacked_messages;
    set_mode(1'b0);
    send_beat(octet_beat(8'h9b, 1'b0));
    send_beat(octet_beat(8'hc1, 1'b0));
    send_beat(octet_beat(8'h80, 1'b0));
    send_beat(octet_beat(8'h7f, 1'b0));
    send_beat(octet_beat(8'hff, 1'b1));
    send_message('{7'h03, gsm7_pkg::ESC_SEPTET});
    send_message('{gsm7_pkg::ESC_SEPTET, gsm7_pkg::ESC_SEPTET, 7'h28});
  endtask

  task automatic test_mode_switch;
    set_mode(1'b1);
    send_beat(octet_beat(8'hd5, 1'b0));
    send_beat(octet_beat(8'h1b, 1'b0));
    send_beat(octet_beat(8'h6e, 1'b0));
    set_mode(1'b0);
    send_beat(octet_beat(8'h1b, 1'b0));
    send_beat(octet_beat(8'hb7, 1'b0));
    set_mode(1'b1);
    send_beat(octet_beat(8'hf0, 1'b0));
    send_beat(octet_beat(8'h0f, 1'b1));
  endtask

  task automatic test_backpressure;
    logic [6:0] septs[$];
    quiesce();
    src_bursts = 1'b0;
    sink_bursts = 1'b0;
    hold_req = 1'b1;
    repeat (3) begin
      septs.delete();
      repeat (12) septs.push_back(rand_septet());
      send_message(septs);
    end
    quiesce();
  endtask

  task automatic test_random;
    logic [6:0] septs[$];
    int pick;
    int goal;
    goal = beats_sent + RANDOM_ITEMS;
    src_bursts = 1'b1;
    sink_bursts = 1'b1;
    while (beats_sent < goal) begin
      if (beats_sent >= goal - CALM_ITEMS) begin
        src_bursts = 1'b0;
        sink_bursts = 1'b0;
      end
      if ($urandom_range(0, 11) == 0) set_mode(1'($urandom));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        septs.delete();
        repeat ($urandom_range(1, 16)) septs.push_back(rand_septet());
        send_message(septs);
      end else if (pick == 7) begin
        send_beat(octet_beat(8'($urandom), $urandom_range(0, 3) == 0));
      end else if (pick == 8) begin
        send_beat(load_beat(2'($urandom_range(0, 1)), 7'($urandom), table_word()));
      end else begin
        send_beat(load_beat(OP_RESERVED, 7'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (sink_bursts && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_chars
    char_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: code_unit %h position %0d", code_unit, position);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (code_unit !== want.unit) begin
          $error("code_unit: expected %h, actual %h", want.unit, code_unit);
          mismatch_count++;
        end
        if (position !== want.pos) begin
          $error("position: expected %0d, actual %0d", want.pos, position);
          mismatch_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %b, actual %b", want.last, run_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    src_bursts = 1'b1;
    sink_bursts = 1'b1;
    test_load_tables();
    test_packed_messages();
    test_unpacked_messages();
    test_mode_switch();
    test_backpressure();
    test_random();
    quiesce();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
